>>> rtl/scc_pkg.sv
// shared constants for the shape circularity classifier
`default_nettype none

package scc_pkg;

    // configuration register widths and reset values
    localparam int CFG_DIM_W    = 11;
    localparam int CFG_MARGIN_W = 7;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 2'd2;

    localparam logic [CFG_DIM_W-1:0]    FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_DIM_W-1:0]    FRAME_HEIGHT_RST = 11'd480;
    localparam logic [CFG_MARGIN_W-1:0] MARGIN_RST       = 7'd80;

    // default frame size limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // area and perimeter totals
    localparam int                CNT_W   = 21;
    localparam logic [CNT_W-1:0]  CNT_MAX = 21'h1FFFFF;

    // shared multiplier: 29 x 21 bits, product 50 bits
    localparam int MUL_A_W = 29;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = 50;
    localparam int LO_W    = 49;
    localparam int X_W     = 48;

    // 100 * round(4 * pi * 2^16)
    localparam logic [26:0] K4PI_X100 = 27'd82355000;
    localparam logic [7:0]  PCT_BASE  = 8'd100;

endpackage

`default_nettype wire

>>> rtl/shape_circularity_classifier_top.sv
// shape circularity classifier: area, perimeter and circle test over one binary frame
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | in        | i_in_valid / o_in_ready    | i_pixel_on
//  out     | out       | o_out_valid / i_out_ready  | o_area_count, o_perimeter_count,
//          |           |                            | o_is_circle
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a pixel in the interior test region waits while one line store read port serves the
// reads of the centre pixel and three of its neighbours in turn; any other pixel goes straight to update
// the last pixel of a frame adds the circle test on one shared 29 x 21 multiplier
// (five products, one compare pass) before the result item is loaded into the output register
// the next frame is taken while a result waits; a second result waits until the first is taken
// reset is synchronous and active low; line store not cleared; writes taken only when idle
`default_nettype none

module shape_circularity_classifier_top #(
    parameter int MAX_WIDTH  = scc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = scc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_pixel_on,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [scc_pkg::CNT_W-1:0]           o_area_count,
    output logic [scc_pkg::CNT_W-1:0]           o_perimeter_count,
    output logic                                o_is_circle,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [scc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [scc_pkg::CFG_DIM_W-1:0]       i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DW    = $clog2(MAX_WIDTH + 1);
    localparam int DH    = $clog2(MAX_HEIGHT + 1);
    localparam int DWC   = (DW > scc_pkg::CFG_DIM_W) ? DW : scc_pkg::CFG_DIM_W;
    localparam int DHC   = (DH > scc_pkg::CFG_DIM_W) ? DH : scc_pkg::CFG_DIM_W;
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = scc_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_MUL,
        S_CMP,
        S_DONE
    } t_state;

    t_state                              r_state;
    logic [scc_pkg::CFG_DIM_W-1:0]       r_frame_width;
    logic [scc_pkg::CFG_DIM_W-1:0]       r_frame_height;
    logic [scc_pkg::CFG_MARGIN_W-1:0]    r_margin;

    logic [CW-1:0]                       r_col;
    logic [RW-1:0]                       r_row;
    logic [1:0]                          r_slot;
    logic [CNT_W-1:0]                    r_area;
    logic [CNT_W-1:0]                    r_perim;

    logic                                r_pix;
    logic                                r_judge;
    logic                                r_center;
    logic                                r_allon;
    logic [1:0]                          r_rstep;
    logic                                r_rd;
    logic                                r_store [DEPTH];

    logic [CNT_W-1:0]                    r_res_area;
    logic [CNT_W-1:0]                    r_res_perim;
    logic [2:0]                          r_mstep;
    logic [scc_pkg::PROD_W-1:0]          r_prod;
    logic [scc_pkg::LO_W-1:0]            r_lo;
    logic [scc_pkg::PROD_W-1:0]          r_hi;
    logic [32:0]                         r_xc;
    logic [31:0]                         r_xf;
    logic                                r_flag;

    logic                                r_out_valid;
    logic [CNT_W-1:0]                    r_out_area;
    logic [CNT_W-1:0]                    r_out_perim;
    logic                                r_out_circle;

    logic [DWC-1:0]                      wide_w;
    logic [DHC-1:0]                      wide_h;
    logic [DW-1:0]                       w;
    logic [DH-1:0]                       h;
    logic [DW-1:0]                       col_p1;
    logic [DH-1:0]                       row_p1;
    logic                                col_last;
    logic                                row_last;
    logic                                judge;
    logic                                on_edge;
    logic [1:0]                          slot_m1;
    logic [1:0]                          slot_m2;
    logic [1:0]                          rd_slot;
    logic [CW-1:0]                       rd_col;
    logic [AW-1:0]                       rd_addr;
    logic [AW-1:0]                       wr_addr;
    logic                                mem_we;
    logic                                hit;
    logic [1:0]                          perim_inc;
    logic [CNT_W:0]                      area_sum;
    logic [CNT_W:0]                      perim_sum;
    logic [CNT_W-1:0]                    n_area;
    logic [CNT_W-1:0]                    n_perim;
    logic [7:0]                          margin_hi;
    logic [scc_pkg::MUL_A_W-1:0]         mul_a;
    logic [scc_pkg::MUL_B_W-1:0]         mul_b;
    logic [scc_pkg::PROD_W-1:0]          mul_p;

    function automatic logic [AW-1:0] f_addr(input logic [1:0] slot, input logic [CW-1:0] col);
        return AW'(slot) * AW'(MAX_WIDTH) + AW'(col);
    endfunction

    // frame size, zero taken as one and clamped to the maximum
    assign wide_w = DWC'(r_frame_width);
    assign wide_h = DHC'(r_frame_height);
    assign w = (r_frame_width == '0) ? DW'(1) :
               (wide_w > DWC'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(wide_w);
    assign h = (r_frame_height == '0) ? DH'(1) :
               (wide_h > DHC'(MAX_HEIGHT)) ? DH'(MAX_HEIGHT) : DH'(wide_h);

    assign col_p1   = DW'(r_col) + DW'(1);
    assign row_p1   = DH'(r_row) + DH'(1);
    assign col_last = (col_p1 == w);
    assign row_last = (row_p1 == h);
    // pixel above the current one is an interior pixel to be judged now
    assign judge    = (r_row >= RW'(2)) && (r_col != '0) && (col_p1 < w);
    assign on_edge  = (r_row == '0) || row_last || (r_col == '0) || col_last;

    // line store rows rotate through three slots
    assign slot_m1 = (r_slot == 2'd0) ? 2'd2 : r_slot - 2'd1;
    assign slot_m2 = (r_slot == 2'd0) ? 2'd1 : (r_slot == 2'd1) ? 2'd2 : 2'd0;

    always_comb begin
        case (r_rstep)
            2'd0:    begin rd_slot = slot_m1; rd_col = r_col;          end
            2'd1:    begin rd_slot = slot_m2; rd_col = r_col;          end
            2'd2:    begin rd_slot = slot_m1; rd_col = r_col - CW'(1); end
            default: begin rd_slot = slot_m1; rd_col = r_col + CW'(1); end
        endcase
    end

    assign rd_addr = f_addr(rd_slot, rd_col);
    assign wr_addr = f_addr(r_slot, r_col);
    assign mem_we  = (r_state == S_UPD);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[wr_addr] <= r_pix;
        end
        r_rd <= r_store[rd_addr];
    end

    // r_rd holds the right-hand neighbour when the update step runs
    assign hit       = r_judge & r_center & ~(r_allon & r_rd & r_pix);
    assign perim_inc = {1'b0, hit} + {1'b0, r_pix & on_edge};
    assign area_sum  = (CNT_W + 1)'(r_area) + (CNT_W + 1)'(r_pix);
    assign perim_sum = (CNT_W + 1)'(r_perim) + (CNT_W + 1)'(perim_inc);
    assign n_area    = (area_sum > (CNT_W + 1)'(scc_pkg::CNT_MAX)) ?
                       scc_pkg::CNT_MAX : area_sum[CNT_W-1:0];
    assign n_perim   = (perim_sum > (CNT_W + 1)'(scc_pkg::CNT_MAX)) ?
                       scc_pkg::CNT_MAX : perim_sum[CNT_W-1:0];

    // shared multiplier operands, one product per step
    assign margin_hi = scc_pkg::PCT_BASE + 8'(r_margin);

    always_comb begin
        case (r_mstep)
            3'd0:    begin mul_a = scc_pkg::MUL_A_W'(r_margin);  mul_b = r_res_perim; end
            3'd1:    begin mul_a = r_prod[scc_pkg::MUL_A_W-1:0]; mul_b = r_res_perim; end
            3'd2:    begin mul_a = scc_pkg::MUL_A_W'(margin_hi); mul_b = r_res_perim; end
            3'd3:    begin mul_a = r_prod[scc_pkg::MUL_A_W-1:0]; mul_b = r_res_perim; end
            3'd4:    begin mul_a = scc_pkg::MUL_A_W'(scc_pkg::K4PI_X100); mul_b = r_res_area; end
            default: begin mul_a = '0;                           mul_b = '0;          end
        endcase
    end

    assign mul_p = scc_pkg::PROD_W'(mul_a) * scc_pkg::PROD_W'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_frame_width  <= scc_pkg::FRAME_WIDTH_RST;
            r_frame_height <= scc_pkg::FRAME_HEIGHT_RST;
            r_margin       <= scc_pkg::MARGIN_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_slot         <= '0;
            r_area         <= '0;
            r_perim        <= '0;
            r_rstep        <= '0;
            r_mstep        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            // the done step reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pix   <= i_pixel_on;
                        r_judge <= judge;
                        r_allon <= 1'b1;
                        r_rstep <= '0;
                        r_state <= judge ? S_READ : S_UPD;
                    end
                end
                S_READ: begin
                    // fold in the value read on the previous cycle
                    if (r_rstep == 2'd1) begin
                        r_center <= r_rd;
                    end else if (r_rstep != 2'd0) begin
                        r_allon <= r_allon & r_rd;
                    end
                    r_rstep <= r_rstep + 2'd1;
                    if (r_rstep == 2'd3) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (col_last && row_last) begin
                        r_res_area  <= n_area;
                        r_res_perim <= n_perim;
                        r_area      <= '0;
                        r_perim     <= '0;
                        r_col       <= '0;
                        r_row       <= '0;
                        r_slot      <= '0;
                        r_mstep     <= '0;
                        r_state     <= S_MUL;
                    end else begin
                        r_area  <= n_area;
                        r_perim <= n_perim;
                        if (col_last) begin
                            r_col  <= '0;
                            r_row  <= r_row + RW'(1);
                            r_slot <= (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_p;
                    r_mstep <= r_mstep + 3'd1;
                    if (r_mstep == 3'd2) begin
                        r_lo <= r_prod[scc_pkg::LO_W-1:0];
                    end
                    if (r_mstep == 3'd4) begin
                        r_hi <= r_prod;
                    end
                    if (r_mstep == 3'd5) begin
                        // ceiling and floor of the area term over 2^16
                        r_xc    <= 33'(r_prod[scc_pkg::X_W-1:16]) + 33'(|r_prod[15:0]);
                        r_xf    <= r_prod[scc_pkg::X_W-1:16];
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_flag  <= (r_res_perim != '0) &&
                               (scc_pkg::PROD_W'(r_lo) < scc_pkg::PROD_W'(r_xc)) &&
                               (scc_pkg::PROD_W'(r_xf) < r_hi);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_area   <= r_res_area;
                        r_out_perim  <= r_res_perim;
                        r_out_circle <= r_flag;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_valid && (r_state == S_IDLE)) begin
                unique case (i_cfg_index)
                    scc_pkg::CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data;
                        r_col         <= '0;
                        r_row         <= '0;
                        r_slot        <= '0;
                        r_area        <= '0;
                        r_perim       <= '0;
                    end
                    scc_pkg::CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data;
                        r_col          <= '0;
                        r_row          <= '0;
                        r_slot         <= '0;
                        r_area         <= '0;
                        r_perim        <= '0;
                    end
                    scc_pkg::CFG_MARGIN: begin
                        r_margin <= i_cfg_data[scc_pkg::CFG_MARGIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_area_count      = r_out_area;
    assign o_perimeter_count = r_out_perim;
    assign o_is_circle       = r_out_circle;
    assign o_cfg_ready       = (r_state == S_IDLE);

    a_circle_needs_perimeter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_circle) |-> (o_perimeter_count != '0))
        else $error("circle flagged with zero perimeter");

    a_perimeter_within_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_perimeter_count <= o_area_count))
        else $error("perimeter exceeds area");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item taken while previous item still in work");

    a_column_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (DW'(r_col) < w))
        else $error("column position beyond frame width");

endmodule

`default_nettype wire
